/* hdl/psc_pkg.sv */
package psc_pkg;

	// Payload widths
	localparam int CHAR_W    = 8;
	localparam int CNT_W     = 16;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 24;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Top-level load/walk control
	typedef enum logic [1:0] {
		T_LOAD = 2'b01,
		T_WALK = 2'b10
	} top_state_t;

	// Center-expansion sequencer
	typedef enum logic [3:0] {
		W_IDLE = 4'b0001,
		W_READ = 4'b0010,
		W_CMP  = 4'b0100,
		W_DONE = 4'b1000
	} walk_state_t;

	// Walk result handed to the top level
	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] count;
	} walk_res_t;

endpackage

/* hdl/psc_mem.sv */
module psc_mem
	import psc_pkg::*;
#(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [CHAR_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [CHAR_W-1:0] rd_data_a,
	output logic [CHAR_W-1:0] rd_data_b
);

	logic [CHAR_W-1:0] mem_q [DEPTH];

	// One write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

/* hdl/psc_walk.sv */
module psc_walk
	import psc_pkg::*;
#(
	parameter int ADDR_W = 8,
	parameter int LEN_W  = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              ack,
	input  logic [LEN_W-1:0]  len,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr_a,
	output logic [ADDR_W-1:0] rd_addr_b,
	input  logic [CHAR_W-1:0] rd_data_a,
	input  logic [CHAR_W-1:0] rd_data_b,
	output walk_res_t         res
);

	walk_state_t       state_q;
	logic [ADDR_W-1:0] c_q;
	logic [ADDR_W-1:0] l_q;
	logic [LEN_W-1:0]  r_q;
	logic              odd_q;
	logic [CNT_W-1:0]  total_q;

	logic in_range;
	logic bytes_eq;
	logic end_walk;
	logic last_ctr;

	// Shared compare unit and walk termination
	assign in_range = (r_q < len);
	assign bytes_eq = (rd_data_a == rd_data_b);
	assign last_ctr = ((LEN_W'(c_q) + LEN_W'(1)) == len);
	assign end_walk = ((state_q == W_READ) && !in_range) ||
		((state_q == W_CMP) && (!bytes_eq || (l_q == '0)));

	assign rd_en     = (state_q == W_READ) && in_range;
	assign rd_addr_a = l_q;
	assign rd_addr_b = r_q[ADDR_W-1:0];

	assign res.done  = (state_q == W_DONE);
	assign res.count = total_q;

	// Sequencer: per center an odd walk then an even walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			c_q     <= '0;
			l_q     <= '0;
			r_q     <= '0;
			odd_q   <= 1'b0;
			total_q <= '0;
		end else begin
			if ((state_q == W_CMP) && bytes_eq && (total_q != CNT_MAX)) begin
				total_q <= total_q + CNT_W'(1);
			end
			if (end_walk) begin
				if (odd_q) begin
					odd_q   <= 1'b0;
					l_q     <= c_q;
					r_q     <= LEN_W'(c_q) + LEN_W'(1);
					state_q <= W_READ;
				end else if (last_ctr) begin
					state_q <= W_DONE;
				end else begin
					c_q     <= c_q + ADDR_W'(1);
					l_q     <= c_q + ADDR_W'(1);
					r_q     <= LEN_W'(c_q) + LEN_W'(1);
					odd_q   <= 1'b1;
					state_q <= W_READ;
				end
			end else begin
				case (state_q)
					W_IDLE: begin
						if (start) begin
							c_q     <= '0;
							l_q     <= '0;
							r_q     <= '0;
							odd_q   <= 1'b1;
							total_q <= '0;
							state_q <= W_READ;
						end
					end
					W_READ: begin
						state_q <= W_CMP;
					end
					W_CMP: begin
						// match and room to go outward
						l_q     <= l_q - ADDR_W'(1);
						r_q     <= r_q + LEN_W'(1);
						state_q <= W_READ;
					end
					W_DONE: begin
						if (ack) begin
							state_q <= W_IDLE;
						end
					end
					default: begin
						state_q <= W_IDLE;
					end
				endcase
			end
		end
	end

`ifndef SYNTH
	// Right index never falls behind the left one during a compare
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == W_CMP) |-> (LEN_W'(l_q) <= r_q))
		else $error("walk: right index behind left index");

	// Total only grows while a walk is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != W_IDLE) && ($past(state_q) != W_IDLE)) |-> (total_q >= $past(total_q)))
		else $error("walk: running total decreased");

	// Every stored byte is a palindrome of its own
	assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (total_q >= CNT_W'(len)))
		else $error("walk: total below string length");
`endif

endmodule

/* hdl/palindromic_substring_counter.sv */
// Palindromic substring counter.
// Input stream: one byte per transaction on s_axis, s_axis_tlast on the final
// byte. Bytes go into a MAX_LEN-entry buffer; bytes past MAX_LEN are dropped
// and flagged as truncated.
// After the final byte is taken s_axis_tready drops while a sequencer walks
// every center, first around one byte, then between it and the next, using
// one byte compare on a two-port buffer read: each compared pair takes a read
// state and a compare state, each walk that stops at the string end one more
// read state. Loading runs at one byte per cycle.
// Output stream: one transaction per string on m_axis carrying the count
// (saturating at 65535) and the truncated flag. The result sits in an output
// register; while m_axis_tready is low the next string is still loaded, and
// its walk result waits in the sequencer until the register frees up.
// Reset (arst_n low) empties the buffer length, clears the truncated flag,
// drops m_axis_tvalid and returns the block to loading.
module palindromic_substring_counter
	import psc_pkg::*;
#(
	parameter int MAX_LEN = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] char_code
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata   // [15:0] palindrome_count, [16] truncated
);

	localparam int ADDR_W = $clog2(MAX_LEN);
	localparam int LEN_W  = $clog2(MAX_LEN + 1);

	top_state_t        state_q;
	logic [LEN_W-1:0]  len_q;
	logic              ovf_q;
	logic              start_q;
	logic              m_valid_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_trunc_q;

	logic              in_acc;
	logic              has_room;
	logic              out_free;
	logic              ack;
	logic              wr_en;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic [CHAR_W-1:0] rd_data_a;
	logic [CHAR_W-1:0] rd_data_b;
	walk_res_t         walk_res;

	// Handshakes
	assign s_axis_tready = (state_q == T_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign has_room      = (len_q < LEN_W'(MAX_LEN));
	assign wr_en         = in_acc && has_room;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign ack           = (state_q == T_WALK) && walk_res.done && out_free;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W - CNT_W - 1){1'b0}}, out_trunc_q, out_count_q};

	psc_mem #(
		.DEPTH  (MAX_LEN),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (len_q[ADDR_W-1:0]),
		.wr_data   (s_axis_tdata[CHAR_W-1:0]),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	psc_walk #(
		.ADDR_W (ADDR_W),
		.LEN_W  (LEN_W)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.ack       (ack),
		.len       (len_q),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.res       (walk_res)
	);

	// Load control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_LOAD;
			len_q     <= '0;
			ovf_q     <= 1'b0;
			start_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			start_q <= in_acc && s_axis_tlast;
			if (ack) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				T_LOAD: begin
					if (in_acc) begin
						if (has_room) begin
							len_q <= len_q + LEN_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							state_q <= T_WALK;
						end
					end
				end
				T_WALK: begin
					if (ack) begin
						len_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= T_LOAD;
					end
				end
				default: begin
					state_q <= T_LOAD;
				end
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ack) begin
			out_count_q <= walk_res.count;
			out_trunc_q <= ovf_q;
		end
	end

`ifndef SYNTH
	// Final byte closes the input until the result is handed over
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
		else $error("top: input still open after final byte");

	// Stored length never exceeds the buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LEN))
		else $error("top: stored length beyond buffer depth");

	// Truncation only once the buffer is full
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LEN_W'(MAX_LEN)))
		else $error("top: truncation flagged with buffer not full");
`endif

endmodule

/* bench/tb_palindromic_substring_counter.sv */
module tb_palindromic_substring_counter
	import psc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STR_MAX        = 256;
	// longest quiet stretch: a full-length walk plus stalls
	localparam int WATCHDOG_LIMIT = 400000;
	localparam int HOLD_CYCLES    = 4000;
	localparam int DRAIN_CYCLES   = 1000;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             truncated;
	} pal_result_t;

	typedef enum int {
		FILL_RAND,
		FILL_ABC,
		FILL_CONST
	} fill_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic                 s_axis_tlast  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	char_item_t  pending_chars[$];
	pal_result_t expected_counts[$];

	// shadow of the string being loaded
	logic [CHAR_W-1:0] str_buf [STR_MAX];
	int                str_len   = 0;
	logic              str_trunc = 1'b0;

	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	bit hold_req          = 1'b0;
	int hold_left         = 0;
	bit in_accepted       = 1'b0;
	int error_count       = 0;
	int quiet_cycles      = 0;

	palindromic_substring_counter #(
		.MAX_LEN(STR_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),   // [7:0] char_code
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)    // [15:0] palindrome_count, [16] truncated
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Center expansion over the shadow string, saturating total
	function automatic logic [CNT_W-1:0] count_palindromes();
		int total;
		int lo;
		int hi;
		total = 0;
		for (int c = 0; c < str_len; c++) begin
			for (int w = 0; w < 2; w++) begin
				lo = c;
				hi = c + w;
				while (lo >= 0 && hi < str_len && str_buf[lo] == str_buf[hi]) begin
					if (total < CNT_MAX)
						total++;
					lo--;
					hi++;
				end
			end
		end
		return total[CNT_W-1:0];
	endfunction

	task automatic push_char(input logic [CHAR_W-1:0] code, input logic last);
		char_item_t item;
		item.code = code;
		item.last = last;
		pending_chars = {pending_chars, item};
	endtask

	task automatic push_string(input int len, input fill_t fill, input logic [CHAR_W-1:0] base);
		logic [CHAR_W-1:0] code;
		for (int k = 0; k < len; k++) begin
			case (fill)
				FILL_RAND: code = CHAR_W'($urandom_range(255));
				FILL_ABC:  code = base + CHAR_W'($urandom_range(2));
				default:   code = base;
			endcase
			push_char(code, k == len - 1);
		end
	endtask

	// Mostly short strings over a tiny alphabet so palindromes are common
	task automatic push_random(input int n_chars);
		int    pushed;
		int    len;
		int    sel;
		fill_t fill;
		pushed = 0;
		while (pushed < n_chars) begin
			sel = $urandom_range(99);
			if (sel < 80)
				len = $urandom_range(1, 12);
			else
				len = $urandom_range(13, 40);
			sel = $urandom_range(99);
			if (sel < 50)
				fill = FILL_ABC;
			else if (sel < 80)
				fill = FILL_RAND;
			else
				fill = FILL_CONST;
			push_string(len, fill, CHAR_W'($urandom_range(255)));
			pushed += len;
		end
	endtask

	task automatic wait_drained();
		while (pending_chars.size() != 0 || s_axis_tvalid || expected_counts.size() != 0)
			@(posedge clk);
	endtask

	// Input driver, updates at the falling edge
	always @(negedge clk) begin
		char_item_t item;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_accepted) begin
			if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				item = pending_chars.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= item.code;
				s_axis_tlast  <= item.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output ready, with random idling and an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		pal_result_t want;
		pal_result_t got;
		bit          out_accepted;
		in_accepted  = arst_n && s_axis_tvalid && s_axis_tready;
		out_accepted = arst_n && m_axis_tvalid && m_axis_tready;

		if (in_accepted) begin
			if (str_len < STR_MAX) begin
				str_buf[str_len] = s_axis_tdata[CHAR_W-1:0];
				str_len++;
			end else begin
				str_trunc = 1'b1;
			end
			if (s_axis_tlast) begin
				want.count      = count_palindromes();
				want.truncated  = str_trunc;
				expected_counts = {expected_counts, want};
				str_len   = 0;
				str_trunc = 1'b0;
			end
		end

		if (out_accepted) begin
			got.count     = m_axis_tdata[CNT_W-1:0];
			got.truncated = m_axis_tdata[CNT_W];
			if (expected_counts.size() == 0) begin
				$error("unexpected result: palindrome_count=%0d truncated=%0d",
					got.count, got.truncated);
				error_count++;
			end else begin
				want = expected_counts.pop_front();
				if (got.count !== want.count) begin
					$error("palindrome_count: expected %0d, actual %0d", want.count, got.count);
					error_count++;
				end
				if (got.truncated !== want.truncated) begin
					$error("truncated: expected %0d, actual %0d", want.truncated, got.truncated);
					error_count++;
				end
			end
		end

		// watchdog on cycles with no transaction on either side
		if (in_accepted || out_accepted)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		sender_idle_pct   = 25;
		receiver_idle_pct = 72;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single bytes, byte extremes, even/odd palindromes, no match
		push_char(8'h00, 1'b1);
		push_char(8'hFF, 1'b1);
		push_char(8'hFF, 1'b0);
		push_char(8'hFF, 1'b1);
		push_char(8'h00, 1'b0);
		push_char(8'hFF, 1'b1);
		push_char(8'h61, 1'b0);
		push_char(8'h62, 1'b0);
		push_char(8'h61, 1'b1);
		push_char(8'h61, 1'b0);
		push_char(8'h62, 1'b0);
		push_char(8'h62, 1'b0);
		push_char(8'h61, 1'b1);
		push_char(8'h61, 1'b0);
		push_char(8'h62, 1'b0);
		push_char(8'h63, 1'b1);
		push_string(5, FILL_CONST, 8'h7E);
		push_string(4, FILL_RAND, 8'h00);

		// phase 1: slow receiver; ends with a full buffer of one byte (largest count for the buffer)
		push_random(400);
		push_string(STR_MAX, FILL_CONST, 8'h41);
		wait_drained();

		// phase 2: slow sender; ends with an overlong string, final byte dropped
		sender_idle_pct   = 72;
		receiver_idle_pct = 25;
		push_random(400);
		push_string(STR_MAX + 4, FILL_ABC, 8'h61);
		wait_drained();

		// phase 3: no idling, but the receiver holds off at the start
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		hold_req          = 1'b1;
		push_random(400);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_counts.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
